// ===== hdl/mst_pkg.sv =====
// Shared definitions for the multitouch slot tracker: field widths, event codes
// and the control record passed to the position scaler.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mst_pkg;

  localparam int unsigned TYPE_W  = 5;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned ID_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEF_SLOT_COUNT      = 10;
  localparam int unsigned DEF_SCALE_FRAC_BITS = 8;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
  localparam int unsigned ID_BASE = 10;

  // Event types.
  localparam logic [TYPE_W-1:0] T_SYN = 5'd0;
  localparam logic [TYPE_W-1:0] T_KEY = 5'd1;
  localparam logic [TYPE_W-1:0] T_ABS = 5'd3;

  // Event codes.
  localparam logic [CODE_W-1:0] C_SYN_REPORT      = 10'h000;
  localparam logic [CODE_W-1:0] C_SYN_DROPPED     = 10'h003;
  localparam logic [CODE_W-1:0] C_ABS_X           = 10'h000;
  localparam logic [CODE_W-1:0] C_ABS_Y           = 10'h001;
  localparam logic [CODE_W-1:0] C_MT_SLOT         = 10'h02f;
  localparam logic [CODE_W-1:0] C_MT_POS_X        = 10'h035;
  localparam logic [CODE_W-1:0] C_MT_POS_Y        = 10'h036;
  localparam logic [CODE_W-1:0] C_MT_TRACK        = 10'h039;
  localparam logic [CODE_W-1:0] C_BTN_TOOL_FINGER = 10'h145;
  localparam logic [CODE_W-1:0] C_BTN_TOUCH       = 10'h14a;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 2'd1;

  // Control of the scaler: load captures the operands, calc registers the product.
  typedef struct packed {
    logic load;
    logic calc;
  } mst_scale_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/mst_scaler.sv =====
// Position scaler: signed coordinate times unsigned fixed-point scale, then a
// division by a power of two rounded towards zero and saturated to 32 bits.
// Depends on mst_pkg.
`default_nettype none

module mst_scaler #(
  parameter int unsigned FRAC_BITS = mst_pkg::DEF_SCALE_FRAC_BITS
) (
  input  wire                              clk,
  input  wire mst_pkg::mst_scale_ctrl_t    ctrl,
  input  wire logic signed [mst_pkg::VALUE_W-1:0] value,
  input  wire logic [mst_pkg::SCALE_W-1:0] scale,
  output logic signed [mst_pkg::VALUE_W-1:0]      result
);
  import mst_pkg::*;

  localparam int unsigned PROD_W = VALUE_W + SCALE_W + 1;
  localparam logic [PROD_W-1:0] BIAS = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [VALUE_W-1:0] op_value;
  logic        [SCALE_W-1:0] op_scale;
  logic signed [PROD_W-1:0]  product;
  logic signed [PROD_W-1:0]  biased;
  logic signed [PROD_W-1:0]  shifted;
  logic                      fits;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_value <= value;
      op_scale <= scale;
    end
    if (ctrl.calc) begin
      product <= $signed(op_value) * $signed({1'b0, op_scale});
    end
  end

  // Negative products are biased so that the arithmetic shift truncates towards zero.
  always_comb begin
    biased  = product + (product[PROD_W-1] ? $signed(BIAS) : $signed(PROD_W'(0)));
    shifted = biased >>> FRAC_BITS;
    fits    = (&shifted[PROD_W-1:VALUE_W-1]) || !(|shifted[PROD_W-1:VALUE_W-1]);
    if (fits) begin
      result = shifted[VALUE_W-1:0];
    end else if (shifted[PROD_W-1]) begin
      result = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/multitouch_slot_tracker.sv =====
// Multitouch slot tracker, top level: event decode, slot table, frame sequencer
// and output register. Depends on mst_pkg and mst_scaler.
//
//  channel  direction  handshake            payload
//  in       request    in_valid / in_stall  ev_type, ev_code, ev_value
//  out      result     out_valid / out_stall out_type, out_code, out_value, last
//  cfg      write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Slot, tracking and drop requests are applied on acceptance. A position request goes
// through accept, multiply in the shared scaler, then saturate and write back.
// A sync report walks every slot and then emits the touch, tool and sync results;
// the single output register sets a pace of one result per cycle while not stalled.
// Reset clears the whole slot table and loads both scales with 1.0 (256 in Q8.8).
// A stall on the output freezes the frame walk; in_stall is high whenever a request
// is in progress, and configuration writes are always ready.
`default_nettype none

module multitouch_slot_tracker #(
  parameter int unsigned SLOT_COUNT      = mst_pkg::DEF_SLOT_COUNT,
  parameter int unsigned SCALE_FRAC_BITS = mst_pkg::DEF_SCALE_FRAC_BITS
) (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       in_valid,
  output logic                                      in_stall,
  input  wire logic        [mst_pkg::TYPE_W-1:0]    ev_type,
  input  wire logic        [mst_pkg::CODE_W-1:0]    ev_code,
  input  wire logic signed [mst_pkg::VALUE_W-1:0]   ev_value,
  output logic                                      out_valid,
  input  wire                                       out_stall,
  output logic             [mst_pkg::TYPE_W-1:0]    out_type,
  output logic             [mst_pkg::CODE_W-1:0]    out_code,
  output logic signed      [mst_pkg::VALUE_W-1:0]   out_value,
  output logic                                      last,
  input  wire                                       cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [mst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [mst_pkg::SCALE_W-1:0]   cfg_data
);
  import mst_pkg::*;

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_WB    = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_TOUCH = 3'd4;
  localparam logic [2:0] S_TOOL  = 3'd5;
  localparam logic [2:0] S_SYN   = 3'd6;

  // Steps of the per-slot walk during a frame.
  localparam logic [2:0] STEP_SLOT = 3'd0;
  localparam logic [2:0] STEP_ID   = 3'd1;
  localparam logic [2:0] STEP_MTX  = 3'd2;
  localparam logic [2:0] STEP_MTY  = 3'd3;
  localparam logic [2:0] STEP_AX   = 3'd4;
  localparam logic [2:0] STEP_AY   = 3'd5;
  localparam logic [2:0] STEP_REL  = 3'd6;

  // Slot table.
  logic [SLOT_COUNT-1:0]     pressed;
  logic [SLOT_COUNT-1:0]     reported;
  logic [ID_W-1:0]           track_id [SLOT_COUNT];
  logic signed [VALUE_W-1:0] pos_x [SLOT_COUNT];
  logic signed [VALUE_W-1:0] pos_y [SLOT_COUNT];
  logic [SLOT_W-1:0]         cur_slot;
  logic [SCALE_W-1:0]        scale_x;
  logic [SCALE_W-1:0]        scale_y;

  // Sequencer.
  logic [2:0]        state, state_next;
  logic [2:0]        step, step_next;
  logic [SLOT_W-1:0] walk_slot, walk_slot_next;
  logic [1:0]        active, active_next;  // pressed slots seen, saturating at two
  logic              sel_y;

  logic                      in_accept;
  logic                      can_load;
  logic                      emit, adv, set_rep, clr_rep;
  logic [TYPE_W-1:0]         e_type;
  logic [CODE_W-1:0]         e_code;
  logic signed [VALUE_W-1:0] e_value;
  logic                      e_last;
  logic                      is_pos;
  logic                      pressed_w, rep_w;

  mst_scale_ctrl_t           scale_ctrl;
  logic signed [VALUE_W-1:0] scaled;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign can_load  = !out_valid || !out_stall;
  assign is_pos    = (ev_type == T_ABS) && ((ev_code == C_MT_POS_X) || (ev_code == C_MT_POS_Y));
  assign pressed_w = pressed[walk_slot];
  assign rep_w     = reported[walk_slot];

  assign scale_ctrl.load = in_accept && is_pos;
  assign scale_ctrl.calc = (state == S_MUL);

  // The one multiplier of the block, shared by both axes.
  mst_scaler #(
    .FRAC_BITS (SCALE_FRAC_BITS)
  ) u_scaler (
    .clk    (clk),
    .ctrl   (scale_ctrl),
    .value  (ev_value),
    .scale  ((ev_code == C_MT_POS_Y) ? scale_y : scale_x),
    .result (scaled)
  );

  // Frame sequencer: one result per cycle whenever the output register can take it.
  always_comb begin
    state_next     = state;
    step_next      = step;
    walk_slot_next = walk_slot;
    active_next    = active;
    emit           = 1'b0;
    adv            = 1'b0;
    set_rep        = 1'b0;
    clr_rep        = 1'b0;
    e_type         = T_ABS;
    e_code         = C_MT_SLOT;
    e_value        = '0;
    e_last         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept && is_pos) begin
          state_next = S_MUL;
        end else if (in_accept && (ev_type == T_SYN) && (ev_code == C_SYN_REPORT)) begin
          state_next     = S_WALK;
          step_next      = STEP_SLOT;
          walk_slot_next = '0;
          active_next    = '0;
        end
      end
      S_MUL: state_next = S_WB;
      S_WB:  state_next = S_IDLE;
      S_WALK: begin
        if (can_load) begin
          unique case (step)
            STEP_SLOT: begin
              e_value = VALUE_W'(walk_slot);
              if (pressed_w) begin
                emit        = 1'b1;
                active_next = (active == 2'd2) ? 2'd2 : active + 2'd1;
                step_next   = rep_w ? STEP_MTX : STEP_ID;
              end else if (rep_w) begin
                emit      = 1'b1;
                step_next = STEP_REL;
              end else begin
                adv = 1'b1;
              end
            end
            STEP_ID: begin
              emit      = 1'b1;
              e_code    = C_MT_TRACK;
              e_value   = VALUE_W'(track_id[walk_slot]);
              step_next = STEP_MTX;
            end
            STEP_MTX: begin
              emit      = 1'b1;
              e_code    = C_MT_POS_X;
              e_value   = pos_x[walk_slot];
              step_next = STEP_MTY;
            end
            STEP_MTY: begin
              emit      = 1'b1;
              e_code    = C_MT_POS_Y;
              e_value   = pos_y[walk_slot];
              step_next = STEP_AX;
            end
            STEP_AX: begin
              emit      = 1'b1;
              e_code    = C_ABS_X;
              e_value   = pos_x[walk_slot];
              step_next = STEP_AY;
            end
            STEP_AY: begin
              emit    = 1'b1;
              e_code  = C_ABS_Y;
              e_value = pos_y[walk_slot];
              set_rep = 1'b1;
              adv     = 1'b1;
            end
            STEP_REL: begin
              emit    = 1'b1;
              e_code  = C_MT_TRACK;
              e_value = '1;
              clr_rep = 1'b1;
              adv     = 1'b1;
            end
            default: step_next = STEP_SLOT;
          endcase
        end
        if (adv) begin
          step_next = STEP_SLOT;
          if (walk_slot == LAST_SLOT) begin
            state_next = S_TOUCH;
          end else begin
            walk_slot_next = walk_slot + 1'b1;
          end
        end
      end
      S_TOUCH: begin
        if (can_load) begin
          emit       = 1'b1;
          e_type     = T_KEY;
          e_code     = C_BTN_TOUCH;
          e_value    = VALUE_W'(active != 2'd0);
          state_next = S_TOOL;
        end
      end
      S_TOOL: begin
        if (can_load) begin
          emit       = 1'b1;
          e_type     = T_KEY;
          e_code     = C_BTN_TOOL_FINGER;
          e_value    = VALUE_W'(active == 2'd1);
          state_next = S_SYN;
        end
      end
      S_SYN: begin
        if (can_load) begin
          emit       = 1'b1;
          e_type     = T_SYN;
          e_code     = C_SYN_REPORT;
          e_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_SLOT;
      walk_slot <= '0;
      active    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      walk_slot <= walk_slot_next;
      active    <= active_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload holds while stalled, since emit only fires when the register can load.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_type  <= e_type;
      out_code  <= e_code;
      out_value <= e_value;
      last      <= e_last;
    end
    if (in_accept) begin
      sel_y <= (ev_code == C_MT_POS_Y);
    end
  end

  // Slot table and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slot <= '0;
      scale_x  <= SCALE_RESET;
      scale_y  <= SCALE_RESET;
      pressed  <= '0;
      reported <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        track_id[i] <= '0;
        pos_x[i]    <= '0;
        pos_y[i]    <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SCALE_X) begin
          scale_x <= cfg_data;
        end else if (cfg_index == CFG_SCALE_Y) begin
          scale_y <= cfg_data;
        end
      end
      if (in_accept && (ev_type == T_SYN) && (ev_code == C_SYN_DROPPED)) begin
        // A dropped sync loses the fingers but keeps the slot pointer and the
        // reported flags, so the next frame lifts what was reported.
        pressed <= '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          track_id[i] <= '0;
          pos_x[i]    <= '0;
          pos_y[i]    <= '0;
        end
      end
      if (in_accept && (ev_type == T_ABS)) begin
        if (ev_code == C_MT_SLOT) begin
          if (ev_value < 0) begin
            cur_slot <= '0;
          end else if (ev_value > $signed(VALUE_W'(SLOT_COUNT - 1))) begin
            cur_slot <= LAST_SLOT;
          end else begin
            cur_slot <= ev_value[SLOT_W-1:0];
          end
        end else if (ev_code == C_MT_TRACK) begin
          if (ev_value == '1) begin
            pressed[cur_slot] <= 1'b0;
          end else begin
            pressed[cur_slot]  <= 1'b1;
            track_id[cur_slot] <= ID_W'(ID_BASE) + ID_W'(cur_slot);
          end
        end
      end
      if (state == S_WB) begin
        // A position alone also presses the finger, keeping its old id.
        if (sel_y) begin
          pos_y[cur_slot] <= scaled;
        end else begin
          pos_x[cur_slot] <= scaled;
        end
        pressed[cur_slot] <= 1'b1;
      end
      if (set_rep) begin
        reported[walk_slot] <= 1'b1;
      end
      if (clr_rep) begin
        reported[walk_slot] <= 1'b0;
      end
    end
  end

  // The slot pointer is clamped on every write, so it never leaves the table.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_slot) < SLOT_COUNT) && (32'(walk_slot) < SLOT_COUNT))
    else $error("slot index beyond the table");

  // Only the closing sync report of a frame carries the last flag.
  a_last_only_sync: assert property (@(posedge clk) disable iff (rst)
    (emit && e_last) |-> (state == S_SYN) && (e_type == T_SYN))
    else $error("last flag outside the closing report");

  // A multiply is always followed by its write back, and nothing is accepted meanwhile.
  a_mul_then_wb: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_WB) && in_stall)
    else $error("scaler sequence broken");

  // A new request is never taken in the middle of a frame walk.
  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> !in_accept)
    else $error("request accepted during a frame");

endmodule

`default_nettype wire
